### design/slle_pkg.sv
`default_nettype none

package slle_pkg;

    localparam int OP_W        = 2;
    localparam int POSITION_W  = 10;
    localparam int DATA_W      = 32;
    localparam int LENGTH_W    = 10;
    localparam int STATUS_W    = 2;

    // s_tdata: position, write_value; m_tdata: read_value, list_length
    localparam int IN_TDATA_W  = ((POSITION_W + DATA_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((DATA_W + LENGTH_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - DATA_W - LENGTH_W;

    typedef enum logic [OP_W-1:0] {
        OP_GET    = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK    = 2'd0,
        STS_INDEX = 2'd1,
        STS_FULL  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_POP,
        S_WALK,
        S_VALUE,
        S_LINK,
        S_UNLINK,
        S_FREE,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

### design/static_linked_list_engine_unit.sv
`default_nettype none

// Positional list held in a cursor array of NODE_COUNT nodes.
// Slave channel: one word per operation; s_tuser carries the op (get, insert,
// delete), s_tdata the 1-based position and the value to insert.
// Master channel: one word per operation; m_tuser carries the status (ok,
// index out of range, no free node), m_tdata the value read or removed and
// the list length after the operation.
// After reset the next-index memory is rebuilt one node per cycle, and the
// block stays not ready until that pass ends; the list is then empty.
// One operation is worked at a time. A rejected word goes straight to its
// result; get walks and reads the value, insert pops a free node, walks and
// links it, delete walks, unlinks and frees it. The walk chases the cursor
// one node per cycle on the single registered next-index read port.
// The result waits in an output register; a new word is accepted while it
// waits, and the finished result of that word is held until m_tready frees
// the register.
module static_linked_list_engine_unit #(
    parameter int NODE_COUNT  = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [slle_pkg::IN_TDATA_W-1:0]    s_tdata,   // position, write_value
    input  logic [slle_pkg::OP_W-1:0]          s_tuser,   // op
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [slle_pkg::OUT_TDATA_W-1:0]   m_tdata,   // read_value, list_length
    output logic [slle_pkg::STATUS_W-1:0]      m_tuser    // status
);
    import slle_pkg::*;

    localparam int IW   = $clog2(NODE_COUNT);
    localparam int CW   = $clog2(NODE_COUNT - 1);
    localparam int CMPW = ((CW > POSITION_W) ? CW : POSITION_W) + 1;
    localparam logic [IW-1:0] HEAD     = IW'(NODE_COUNT - 1);
    localparam logic [IW-1:0] CLR_LAST = IW'(NODE_COUNT - 1);
    localparam logic [IW-1:0] CLR_TAIL = IW'(NODE_COUNT - 2);
    localparam logic [CW-1:0] CNT_MAX  = CW'(NODE_COUNT - 2);

    // node stores
    logic [IW-1:0]          nxt_mem [NODE_COUNT];
    logic [VALUE_WIDTH-1:0] val_mem [NODE_COUNT];
    logic [IW-1:0]          mem_q;
    logic [VALUE_WIDTH-1:0] val_q;

    logic                   nxt_we;
    logic [IW-1:0]          nxt_waddr;
    logic [IW-1:0]          nxt_wdata;
    logic [IW-1:0]          rd_addr;
    logic                   val_we;
    logic [IW-1:0]          val_raddr;

    state_t                 state_reg, state_next;
    logic [IW-1:0]          clr_reg, clr_next;
    logic [IW-1:0]          free_head_reg, free_head_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          steps_reg, steps_next;
    logic [IW-1:0]          prev_reg, prev_next;
    logic [IW-1:0]          node_reg, node_next;
    logic [OP_W-1:0]        op_reg, op_next;
    logic [VALUE_WIDTH-1:0] wval_reg, wval_next;
    logic [VALUE_WIDTH-1:0] rval_reg, rval_next;
    status_t                status_reg, status_next;

    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic [STATUS_W-1:0]    m_tuser_reg;

    logic [OP_W-1:0]        in_op;
    logic [POSITION_W-1:0]  in_pos;
    logic [DATA_W-1:0]      in_wval;
    logic [CMPW-1:0]        pos_ext;
    logic [CMPW-1:0]        limit;
    logic                   op_known;
    logic                   pos_ok;
    logic                   is_insert;
    logic                   out_free;
    logic                   load_out;

    assign in_op   = s_tuser;
    assign in_pos  = s_tdata[POSITION_W-1:0];
    assign in_wval = s_tdata[POSITION_W +: DATA_W];

    assign is_insert = (in_op == OP_INSERT);
    assign op_known  = (in_op == OP_GET) || (in_op == OP_INSERT) || (in_op == OP_DELETE);
    assign pos_ext   = CMPW'(in_pos);
    assign limit     = CMPW'(count_reg) + (is_insert ? CMPW'(1) : CMPW'(0));
    assign pos_ok    = (pos_ext != '0) && (pos_ext <= limit);

    assign out_free  = !m_tvalid_reg || m_tready;
    assign load_out  = (state_reg == S_DONE) && out_free;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                if (clr_reg == CLR_LAST) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    priority if (!op_known || !pos_ok) state_next = S_DONE;
                    else if (is_insert && free_head_reg == '0) state_next = S_DONE;
                    else if (is_insert) state_next = S_POP;
                    else state_next = S_WALK;
                end
            end
            S_POP: state_next = S_WALK;
            S_WALK: begin
                if (steps_reg == '0) begin
                    unique case (op_reg)
                        OP_GET:    state_next = S_VALUE;
                        OP_INSERT: state_next = S_LINK;
                        default:   state_next = S_UNLINK;
                    endcase
                end
            end
            S_VALUE:  state_next = S_DONE;
            S_LINK:   state_next = S_DONE;
            S_UNLINK: state_next = S_FREE;
            S_FREE:   state_next = S_DONE;
            S_DONE: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_CLEAR;
        endcase
    end

    // datapath and memory control
    always_comb begin
        s_tready       = 1'b0;
        nxt_we         = 1'b0;
        nxt_waddr      = prev_reg;
        nxt_wdata      = node_reg;
        rd_addr        = mem_q;
        val_we         = 1'b0;
        val_raddr      = mem_q;
        clr_next       = clr_reg;
        free_head_next = free_head_reg;
        count_next     = count_reg;
        steps_next     = steps_reg;
        prev_next      = prev_reg;
        node_next      = node_reg;
        op_next        = op_reg;
        wval_next      = wval_reg;
        rval_next      = rval_reg;
        status_next    = status_reg;
        unique case (state_reg)
            S_CLEAR: begin
                // rebuild free chain: i -> i+1, tail and data head end at 0
                nxt_we    = 1'b1;
                nxt_waddr = clr_reg;
                nxt_wdata = (clr_reg < CLR_TAIL) ? clr_reg + IW'(1) : '0;
                clr_next  = clr_reg + IW'(1);
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    op_next    = in_op;
                    wval_next  = VALUE_WIDTH'(in_wval);
                    rval_next  = '0;
                    steps_next = CW'(pos_ext - CMPW'(1));
                    prev_next  = HEAD;
                    node_next  = free_head_reg;
                    priority if (!op_known) status_next = STS_OK;
                    else if (!pos_ok) status_next = STS_INDEX;
                    else if (is_insert && free_head_reg == '0) status_next = STS_FULL;
                    else status_next = STS_OK;
                    rd_addr = is_insert ? free_head_reg : HEAD;
                end
            end
            S_POP: begin
                // mem_q holds the successor of the taken node
                free_head_next = mem_q;
                val_we         = 1'b1;
                rd_addr        = HEAD;
            end
            S_WALK: begin
                if (steps_reg != '0) begin
                    rd_addr    = mem_q;
                    prev_next  = mem_q;
                    steps_next = steps_reg - CW'(1);
                end else begin
                    unique case (op_reg)
                        OP_GET: begin
                            val_raddr = mem_q;
                        end
                        OP_INSERT: begin
                            nxt_we    = 1'b1;
                            nxt_waddr = node_reg;
                            nxt_wdata = mem_q;
                        end
                        default: begin
                            node_next = mem_q;
                            rd_addr   = mem_q;
                            val_raddr = mem_q;
                        end
                    endcase
                end
            end
            S_VALUE: begin
                rval_next = val_q;
            end
            S_LINK: begin
                nxt_we     = 1'b1;
                nxt_waddr  = prev_reg;
                nxt_wdata  = node_reg;
                count_next = count_reg + CW'(1);
            end
            S_UNLINK: begin
                rval_next = val_q;
                nxt_we    = 1'b1;
                nxt_waddr = prev_reg;
                nxt_wdata = mem_q;
            end
            S_FREE: begin
                // push the removed node onto the free chain
                nxt_we         = 1'b1;
                nxt_waddr      = node_reg;
                nxt_wdata      = free_head_reg;
                free_head_next = node_reg;
                count_next     = count_reg - CW'(1);
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            free_head_reg <= IW'(1);
            count_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            free_head_reg <= free_head_next;
            count_reg     <= count_next;
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        steps_reg  <= steps_next;
        prev_reg   <= prev_next;
        node_reg   <= node_next;
        op_reg     <= op_next;
        wval_reg   <= wval_next;
        rval_reg   <= rval_next;
        status_reg <= status_next;
        if (load_out) begin
            m_tdata_reg <= {{OUT_PAD_W{1'b0}}, LENGTH_W'(count_reg), DATA_W'(rval_reg)};
            m_tuser_reg <= status_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (nxt_we) begin
            nxt_mem[nxt_waddr] <= nxt_wdata;
        end
        mem_q <= nxt_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (val_we) begin
            val_mem[node_reg] <= wval_reg;
        end
        val_q <= val_mem[val_raddr];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_MAX)
        else $error("list length above capacity");

    a_free_not_head: assert property (@(posedge aclk) disable iff (!aresetn)
        free_head_reg != HEAD)
        else $error("data head entered the free chain");

    a_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_LINK && state_reg != S_FREE) |=> $stable(count_reg))
        else $error("length changed outside link or free step");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_DONE))
        else $error("result loaded without a finished operation");

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> !s_tready && !nxt_we || (nxt_waddr == clr_reg))
        else $error("store touched during clearing pass");

endmodule

`default_nettype wire

### tb/testbench.sv
module testbench;
    import slle_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int CAPACITY    = 1022;   // NODE_COUNT - 2 elements fit
    localparam int POS_MAX     = 1023;
    localparam int RANDOM_OPS  = 500;
    localparam int QUIET_LIMIT = 6000;   // covers the clear pass or the longest chase plus both stalls
    localparam int TAIL_CYCLES = 1100;
    localparam int IN_PAD_W    = IN_TDATA_W - POSITION_W - DATA_W;

    typedef struct packed {
        status_t             status;
        logic [DATA_W-1:0]   read_value;
        logic [LENGTH_W-1:0] length;
    } list_result_t;

    typedef struct packed {
        logic [OP_W-1:0]       op;
        logic [POSITION_W-1:0] pos;
        logic [DATA_W-1:0]     value;
        logic                  typed;
        list_result_t          want;
    } directed_row_t;

    localparam list_result_t NO_RESULT = '{STS_OK, 32'h0, 10'd0};

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;    // position, write_value
    logic [OP_W-1:0]        s_tuser;    // op
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;    // read_value, list_length
    logic [STATUS_W-1:0]    m_tuser;    // status

    logic [DATA_W-1:0] shadow_list[$];
    list_result_t      awaited_results[$];

    int  mismatches;
    int  words_sent;
    int  results_checked;
    int  peak_length;
    int  ok_seen;
    int  index_seen;
    int  full_seen;
    int  quiet_cycles = 0;
    bit  sender_steady;

    // Rows marked typed carry a hand-written result; the rest use the list predictor.
    directed_row_t directed_rows [0:23] = '{
        '{OP_GET,    10'd1,    32'h0,        1'b1, '{STS_INDEX, 32'h0,        10'd0}},
        '{OP_DELETE, 10'd1,    32'h0,        1'b1, '{STS_INDEX, 32'h0,        10'd0}},
        '{OP_INSERT, 10'd0,    32'hDEADBEEF, 1'b1, '{STS_INDEX, 32'h0,        10'd0}},
        '{OP_INSERT, 10'd2,    32'hDEADBEEF, 1'b1, '{STS_INDEX, 32'h0,        10'd0}},
        '{OP_INSERT, 10'd1,    32'hFFFFFFFF, 1'b1, '{STS_OK,    32'h0,        10'd1}},
        '{OP_GET,    10'd1,    32'h0,        1'b1, '{STS_OK,    32'hFFFFFFFF, 10'd1}},
        '{OP_INSERT, 10'd1,    32'h00000000, 1'b1, '{STS_OK,    32'h0,        10'd2}},
        '{OP_INSERT, 10'd3,    32'h12345678, 1'b1, '{STS_OK,    32'h0,        10'd3}},
        '{OP_UNUSED, 10'd1023, 32'hFFFFFFFF, 1'b1, '{STS_OK,    32'h0,        10'd3}},
        '{OP_UNUSED, 10'd0,    32'h0,        1'b1, '{STS_OK,    32'h0,        10'd3}},
        '{OP_GET,    10'd0,    32'h0,        1'b1, '{STS_INDEX, 32'h0,        10'd3}},
        '{OP_GET,    10'd1023, 32'h0,        1'b1, '{STS_INDEX, 32'h0,        10'd3}},
        '{OP_GET,    10'd4,    32'h0,        1'b1, '{STS_INDEX, 32'h0,        10'd3}},
        '{OP_DELETE, 10'd4,    32'h0,        1'b1, '{STS_INDEX, 32'h0,        10'd3}},
        '{OP_INSERT, 10'd1023, 32'h0,        1'b1, '{STS_INDEX, 32'h0,        10'd3}},
        '{OP_GET,    10'd2,    32'h0,        1'b0, NO_RESULT},
        '{OP_GET,    10'd3,    32'h0,        1'b0, NO_RESULT},
        '{OP_INSERT, 10'd2,    32'hA5A5A5A5, 1'b0, NO_RESULT},
        '{OP_INSERT, 10'd5,    32'h5A5A5A5A, 1'b0, NO_RESULT},
        '{OP_DELETE, 10'd1,    32'h0,        1'b0, NO_RESULT},
        '{OP_DELETE, 10'd4,    32'h0,        1'b0, NO_RESULT},
        '{OP_GET,    10'd1,    32'h0,        1'b0, NO_RESULT},
        '{OP_DELETE, 10'd0,    32'h0,        1'b1, '{STS_INDEX, 32'h0,        10'd3}},
        '{OP_INSERT, 10'd1,    32'h80000001, 1'b0, NO_RESULT}
    };

    static_linked_list_engine_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Positional list semantics: the free chain only shows up as the capacity limit.
    function automatic list_result_t apply_list_op(input logic [OP_W-1:0] op,
                                                   input logic [POSITION_W-1:0] pos,
                                                   input logic [DATA_W-1:0] value);
        list_result_t res;
        int           len;
        res = '{STS_OK, '0, '0};
        len = shadow_list.size();
        case (op)
            OP_GET: begin
                if (pos < 1 || pos > len)
                    res.status = STS_INDEX;
                else
                    res.read_value = shadow_list[pos - 1];
            end
            OP_INSERT: begin
                if (pos < 1 || pos > len + 1)
                    res.status = STS_INDEX;
                else if (len >= CAPACITY)
                    res.status = STS_FULL;
                else
                    shadow_list.insert(pos - 1, value);
            end
            OP_DELETE: begin
                if (pos < 1 || pos > len) begin
                    res.status = STS_INDEX;
                end else begin
                    res.read_value = shadow_list[pos - 1];
                    shadow_list.delete(pos - 1);
                end
            end
            default: ;
        endcase
        res.length = LENGTH_W'(shadow_list.size());
        if (shadow_list.size() > peak_length)
            peak_length = shadow_list.size();
        return res;
    endfunction

    task automatic note_mismatch(input string what, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] got);
        mismatches++;
        $display("[%0t] result %0d: %s expected %h, got %h",
                 $time, results_checked, what, want, got);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (sender_steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Mostly near the head of the list, sometimes anywhere, a tenth at zero, just past the end or up to POS_MAX.
    function automatic int random_position(input int limit);
        int r;
        int near;
        r = $urandom_range(99);
        if (r < 10) begin
            case ($urandom_range(3))
                0: return 0;
                1: return (limit + 1 > POS_MAX) ? POS_MAX : limit + 1;
                2: return POS_MAX;
                default: return $urandom_range(POS_MAX);
            endcase
        end
        if (limit == 0)
            return 1;
        near = (limit < 16) ? limit : 16;
        if (r < 70)
            return $urandom_range(near, 1);
        return $urandom_range(limit, 1);
    endfunction

    function automatic logic [DATA_W-1:0] random_value();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom;
    endfunction

    task automatic send_op(input logic [OP_W-1:0] op, input int pos,
                           input logic [DATA_W-1:0] value, input bit typed,
                           input list_result_t want);
        int           gap;
        list_result_t predicted;
        if (words_sent % 64 == 0)
            sender_steady = ($urandom_range(3) == 0);
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{IN_PAD_W{1'b0}}, value, pos[POSITION_W-1:0]};
        do @(posedge aclk); while (!s_tready);
        predicted = apply_list_op(op, pos[POSITION_W-1:0], value);
        awaited_results.push_back(typed ? want : predicted);
        words_sent++;
    endtask

    task automatic send_predicted(input logic [OP_W-1:0] op, input int pos,
                                  input logic [DATA_W-1:0] value);
        send_op(op, pos, value, 1'b0, NO_RESULT);
    endtask

    task automatic send_random_op();
        int               r;
        int               len;
        logic [OP_W-1:0]  op;
        len = shadow_list.size();
        r = $urandom_range(99);
        if (r < 4)
            op = OP_UNUSED;
        else if (r < 40)
            op = (len > 300) ? OP_DELETE : OP_INSERT;
        else if (r < 68)
            op = OP_DELETE;
        else
            op = OP_GET;
        send_predicted(op, random_position(op == OP_INSERT ? len + 1 : len), random_value());
    endtask

    // Receiver: ready most of the time, short stalls, a few long ones, calm stretches.
    initial begin : ready_pattern
        int  stall_left;
        int  r;
        bit  steady;
        stall_left = 0;
        steady = 1'b0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if ($urandom_range(255) == 0)
                steady = ~steady;
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                r = $urandom_range(99);
                if (steady || r < 70) begin
                    m_tready <= 1'b1;
                end else begin
                    stall_left = (r < 92) ? $urandom_range(2, 0) : $urandom_range(39, 9);
                    m_tready <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : result_check
        list_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            case (m_tuser)
                STS_OK:    ok_seen++;
                STS_INDEX: index_seen++;
                STS_FULL:  full_seen++;
                default: ;
            endcase
            if (awaited_results.size() == 0) begin
                note_mismatch("word with no operation waiting", '0, m_tdata[DATA_W-1:0]);
            end else begin
                want = awaited_results.pop_front();
                if (m_tuser !== want.status)
                    note_mismatch("status", DATA_W'(want.status), DATA_W'(m_tuser));
                if (m_tdata[DATA_W-1:0] !== want.read_value)
                    note_mismatch("read_value", want.read_value, m_tdata[DATA_W-1:0]);
                if (m_tdata[DATA_W +: LENGTH_W] !== want.length)
                    note_mismatch("list_length", DATA_W'(want.length),
                                  DATA_W'(m_tdata[DATA_W +: LENGTH_W]));
            end
            results_checked++;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("[%0t] no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("static_linked_list_engine_unit regression: fail");
        $finish;
    end

    initial begin
        int len;
        int k;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = OP_GET;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_op(directed_rows[i].op, directed_rows[i].pos, directed_rows[i].value,
                    directed_rows[i].typed, directed_rows[i].want);

        for (k = 0; k < RANDOM_OPS; k++)
            send_random_op();

        // Drain back to empty, deleting near the head so freed nodes return to the free chain out of order.
        while (shadow_list.size() > 0) begin
            len = shadow_list.size();
            if ($urandom_range(15) == 0)
                send_predicted(OP_GET, random_position(len), '0);
            else
                send_predicted(OP_DELETE, $urandom_range((len < 8) ? len : 8, 1), '0);
        end
        send_op(OP_GET, 1, 32'h0, 1'b1, '{STS_INDEX, 32'h0, 10'd0});
        s_tvalid <= 1'b0;

        while (awaited_results.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d operations (%0d table rows), %0d results checked, peak length %0d",
                 words_sent, $size(directed_rows), results_checked, peak_length);
        $display("status mix: %0d ok, %0d out of range, %0d store full; %0d mismatches",
                 ok_seen, index_seen, full_seen, mismatches);
        if (mismatches == 0 && awaited_results.size() == 0)
            $display("static_linked_list_engine_unit regression: pass");
        else
            $display("static_linked_list_engine_unit regression: fail");
        $finish;
    end

endmodule

### sim.f
design/slle_pkg.sv
design/static_linked_list_engine_unit.sv
tb/testbench.sv
